// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers on clk_i with the active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// action and status codes shared by the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
  localparam int DW = 64;

  localparam logic [2:0] ACT_REDUCE = 3'd0;
  localparam logic [2:0] ACT_ADD    = 3'd1;
  localparam logic [2:0] ACT_SUB    = 3'd2;
  localparam logic [2:0] ACT_MUL    = 3'd3;
  localparam logic [2:0] ACT_DIV    = 3'd4;
  localparam logic [2:0] ACT_CMP    = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZDEN    = 2'd1;
  localparam logic [1:0] ST_DIVZ    = 2'd2;
  localparam logic [1:0] ST_OVF     = 2'd3;
endpackage
`default_nettype wire

// ----- sv/rau_gcd.sv -----
// ----------------------------------------------------------------------------
// rau_gcd
// binary gcd, one shift or subtract step per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module rau_gcd (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [rau_pkg::DW-1:0] x_i,
  input  wire logic [rau_pkg::DW-1:0] y_i,
  output logic                       done_o,
  output logic [rau_pkg::DW-1:0]     g_o
);
  import rau_pkg::*;

  logic          busy_q;
  logic [DW-1:0] x_q, y_q;
  logic [5:0]    k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        x_q    <= x_i;
        y_q    <= y_i;
        k_q    <= '0;
      end else if (busy_q) begin
        if (x_q == '0 || y_q == '0) begin
          g_o    <= (x_q | y_q) << k_q;
          done_o <= 1'b1;
          busy_q <= 1'b0;
        end else if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          k_q <= k_q + 6'd1;
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q >= y_q) begin
          x_q <= (x_q - y_q) >> 1;
        end else begin
          y_q <= (y_q - x_q) >> 1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/rau_div.sv -----
// ----------------------------------------------------------------------------
// rau_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module rau_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [rau_pkg::DW-1:0] n_i,
  input  wire logic [rau_pkg::DW-1:0] d_i,
  output logic                       done_o,
  output logic [rau_pkg::DW-1:0]     q_o
);
  import rau_pkg::*;

  logic                  busy_q;
  logic [DW-1:0]         rem_q, d_q;
  logic [$clog2(DW)-1:0] cnt_q;
  logic [DW:0]           rem_sh;
  logic                  take;

  assign rem_sh = {rem_q, q_o[DW-1]};
  assign take   = rem_sh >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        q_o    <= n_i;
        d_q    <= d_i;
        rem_q  <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        rem_q <= take ? DW'(rem_sh - {1'b0, d_q}) : rem_sh[DW-1:0];
        q_o   <= {q_o[DW-2:0], take};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/rational_arith_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arith_unit
// reduce, add, subtract, multiply, divide and compare reduced fractions
// ----------------------------------------------------------------------------
// One transaction at a time: in_ready_o is high only while the unit is idle.
// Operands are reduced, combined with one 32x32 multiplier, then the result is
// reduced again. Each reduction runs the shared binary gcd unit and two passes
// of the shared divider; add and subtract run four gcd and eight divider
// passes.
`default_nettype none
module rational_arith_unit #(
  parameter int WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      res_num_o,
  output logic [30:0]      res_den_o,
  output logic [1:0]       order_o,
  output logic [1:0]       status_o
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_GCD, S_DIV1, S_DIV2, S_P1, S_P2, S_P3, S_ADD, S_CMP, S_FIN, S_OUT
  } state_e;
  typedef enum logic [1:0] {PH_A, PH_B, PH_L, PH_R} phase_e;

  localparam logic [DW-1:0] Lim = DW'(1) << (WIDTH - 1);

  state_e        state_q;
  phase_e        phase_q;
  logic          issued_q;
  logic [2:0]    act_q;
  logic          sa_q, sd_q, sb_q, se_q;
  logic          an_neg_q, bn_neg_q, rneg_q;
  logic [DW-1:0] an_q, ad_q, bn_q, bd_q, t1_q, t2_q, rn_q, rd_q, g_q;
  logic [1:0]    ord_q, status_q;

  logic          gcd_start, gcd_done, div_start, div_done;
  logic [DW-1:0] gcd_x, gcd_y, gcd_g, div_n, div_q;
  logic [31:0]   mul_a, mul_b;
  logic [DW-1:0] mul_p;
  logic          is_addsub;
  logic          y_neg, sum_neg;
  logic [DW-1:0] sum_mag;
  logic [1:0]    cmp_ord;
  logic          ovf;

  function automatic logic [31:0] mag32(input logic [31:0] w);
    return w[31] ? 32'(~w + 32'd1) : w;
  endfunction

  assign is_addsub = (act_q == ACT_ADD) || (act_q == ACT_SUB);

  always_comb begin
    case (phase_q)
      PH_A:    begin gcd_x = an_q; gcd_y = ad_q; end
      PH_B:    begin gcd_x = bn_q; gcd_y = bd_q; end
      PH_L:    begin gcd_x = ad_q; gcd_y = bd_q; end
      default: begin gcd_x = rn_q; gcd_y = rd_q; end
    endcase
    if (state_q == S_DIV1) begin
      case (phase_q)
        PH_A:    div_n = an_q;
        PH_B:    div_n = bn_q;
        PH_L:    div_n = bd_q;
        default: div_n = rn_q;
      endcase
    end else begin
      case (phase_q)
        PH_A:    div_n = ad_q;
        PH_B:    div_n = bd_q;
        PH_L:    div_n = ad_q;
        default: div_n = rd_q;
      endcase
    end
  end

  assign gcd_start = (state_q == S_GCD) && !issued_q;
  assign div_start = ((state_q == S_DIV1) || (state_q == S_DIV2)) && !issued_q;

  rau_gcd u_gcd (
    .clk_i, .rst_ni, .start_i(gcd_start), .x_i(gcd_x), .y_i(gcd_y),
    .done_o(gcd_done), .g_o(gcd_g)
  );

  rau_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(div_n), .d_i(g_q),
    .done_o(div_done), .q_o(div_q)
  );

  // multiplier operand select, every magnitude here fits 32 bits
  always_comb begin
    mul_a = an_q[31:0];
    mul_b = bd_q[31:0];
    if (state_q == S_P1) begin
      case (act_q) inside
        ACT_ADD, ACT_SUB: begin mul_a = t2_q[31:0]; mul_b = bd_q[31:0]; end
        ACT_MUL:          begin mul_a = ad_q[31:0]; mul_b = bd_q[31:0]; end
        ACT_DIV:          begin mul_a = ad_q[31:0]; mul_b = bn_q[31:0]; end
        default:          begin mul_a = bn_q[31:0]; mul_b = ad_q[31:0]; end
      endcase
    end else if (state_q == S_P2) begin
      mul_a = an_q[31:0];
      if (is_addsub)              mul_b = t1_q[31:0];
      else if (act_q == ACT_MUL)  mul_b = bn_q[31:0];
      else                        mul_b = bd_q[31:0];
    end else if (state_q == S_P3) begin
      mul_a = bn_q[31:0];
      mul_b = t2_q[31:0];
    end
  end
  assign mul_p = mul_a * mul_b;

  // signed-magnitude add of t1 and t2
  always_comb begin
    y_neg = bn_neg_q ^ ((act_q == ACT_SUB) && (t2_q != '0));
    if (an_neg_q == y_neg) begin
      sum_neg = an_neg_q;
      sum_mag = t1_q + t2_q;
    end else if (t1_q >= t2_q) begin
      sum_neg = an_neg_q;
      sum_mag = t1_q - t2_q;
    end else begin
      sum_neg = y_neg;
      sum_mag = t2_q - t1_q;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  always_comb begin
    logic ln, rgn;
    ln  = an_neg_q && (t1_q != '0);
    rgn = bn_neg_q && (t2_q != '0);
    if (ln != rgn)       cmp_ord = ln ? 2'b11 : 2'b01;
    else if (t1_q == t2_q) cmp_ord = 2'b00;
    else if (ln)         cmp_ord = (t1_q > t2_q) ? 2'b11 : 2'b01;
    else                 cmp_ord = (t1_q < t2_q) ? 2'b11 : 2'b01;
  end

  assign ovf = (rneg_q ? (rn_q > Lim) : (rn_q > Lim - 1)) || (rd_q > Lim - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_A;
      issued_q <= 1'b0;
    end else begin
      if (gcd_start || div_start) issued_q <= 1'b1;
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          act_q    <= action_i;
          an_q     <= DW'(mag32(a_num_i));
          ad_q     <= DW'(mag32(a_den_i));
          bn_q     <= DW'(mag32(b_num_i));
          bd_q     <= DW'(mag32(b_den_i));
          sa_q     <= a_num_i[31];
          sd_q     <= a_den_i[31];
          sb_q     <= b_num_i[31];
          se_q     <= b_den_i[31];
          ord_q    <= 2'b00;
          status_q <= ST_OK;
          rn_q     <= '0;
          rd_q     <= DW'(1);
          rneg_q   <= 1'b0;
          state_q  <= S_CHK;
        end
        S_CHK: begin
          an_neg_q <= (sa_q != sd_q) && (an_q != '0);
          bn_neg_q <= (sb_q != se_q) && (bn_q != '0);
          phase_q  <= PH_A;
          if (act_q > ACT_CMP) begin
            state_q <= S_OUT;
          end else if (ad_q == '0 || (act_q != ACT_REDUCE && bd_q == '0)) begin
            status_q <= ST_ZDEN;
            state_q  <= S_OUT;
          end else if (act_q == ACT_DIV && bn_q == '0) begin
            status_q <= ST_DIVZ;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_GCD;
          end
        end
        S_GCD: if (gcd_done) begin
          g_q      <= gcd_g;
          issued_q <= 1'b0;
          state_q  <= S_DIV1;
        end
        S_DIV1: if (div_done) begin
          issued_q <= 1'b0;
          state_q  <= S_DIV2;
          case (phase_q)
            PH_A:    an_q <= div_q;
            PH_B:    bn_q <= div_q;
            PH_L:    t1_q <= div_q;
            default: rn_q <= div_q;
          endcase
        end
        S_DIV2: if (div_done) begin
          issued_q <= 1'b0;
          case (phase_q)
            PH_A: begin
              ad_q <= div_q;
              if (act_q == ACT_REDUCE) begin
                rn_q    <= an_q;
                rd_q    <= div_q;
                rneg_q  <= an_neg_q;
                phase_q <= PH_R;
                state_q <= S_GCD;
              end else begin
                phase_q <= PH_B;
                state_q <= S_GCD;
              end
            end
            PH_B: begin
              bd_q <= div_q;
              if (is_addsub) begin
                phase_q <= PH_L;
                state_q <= S_GCD;
              end else begin
                state_q <= S_P1;
              end
            end
            PH_L: begin
              t2_q    <= div_q;
              state_q <= S_P1;
            end
            default: begin
              rd_q    <= div_q;
              state_q <= S_FIN;
            end
          endcase
        end
        S_P1: begin
          if (act_q == ACT_CMP) t2_q <= mul_p;
          else                  rd_q <= mul_p;
          state_q <= S_P2;
        end
        S_P2: begin
          t1_q <= mul_p;
          if (is_addsub)             state_q <= S_P3;
          else if (act_q == ACT_CMP) state_q <= S_CMP;
          else                       state_q <= S_ADD;
        end
        S_P3: begin
          t2_q    <= mul_p;
          state_q <= S_ADD;
        end
        S_ADD: begin
          if (is_addsub) begin
            rn_q   <= sum_mag;
            rneg_q <= sum_neg;
          end else begin
            rn_q   <= t1_q;
            rneg_q <= (an_neg_q != bn_neg_q) && (t1_q != '0);
          end
          phase_q <= PH_R;
          state_q <= S_GCD;
        end
        S_CMP: begin
          ord_q   <= cmp_ord;
          state_q <= S_OUT;
        end
        S_FIN: begin
          if (ovf) begin
            status_q <= ST_OVF;
            rn_q     <= '0;
            rneg_q   <= 1'b0;
            rd_q     <= DW'(1);
          end
          state_q <= S_OUT;
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign res_num_o   = rneg_q ? 32'(~rn_q[31:0] + 32'd1) : rn_q[31:0];
  assign res_den_o   = rd_q[30:0];
  assign order_o     = ord_q;
  assign status_o    = status_q;
endmodule
`default_nettype wire

// ----- sv/rau_checker.sv -----
// ----------------------------------------------------------------------------
// rau_assert
// port-level checks for the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rau_assert (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] res_num_o,
  input wire logic [30:0] res_den_o,
  input wire logic [1:0]  order_o,
  input wire logic [1:0]  status_o
);
  import rau_pkg::*;

  // one transaction in flight at a time
  `AST_IMPL(a_no_overlap, out_valid_o, !in_ready_o, "input ready while result pending")
  `AST_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")
  `AST_IMPL(a_err_zero, out_valid_o && status_o != ST_OK,
            res_num_o == 32'd0 && res_den_o == 31'd1 && order_o == 2'b00,
            "error result is not zero over one")
  `AST_IMPL(a_cmp_zero, out_valid_o && order_o != 2'b00,
            res_num_o == 32'd0 && res_den_o == 31'd1 && status_o == ST_OK,
            "compare result carries a fraction")
  `AST_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(res_num_o),
            "result dropped while stalled")
endmodule

bind rational_arith_unit rau_assert u_rau_assert (.*);
`default_nettype wire

// ----- dv/rau_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rau_checker
// watches both channels of the rational arithmetic unit, predicts every
// result from the accepted operands and compares it field by field
// ----------------------------------------------------------------------------
module rau_checker #(
  parameter int WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [2:0]  action_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] res_num_i,
  input  wire logic [30:0] res_den_i,
  input  wire logic [1:0]  order_i,
  input  wire logic [1:0]  status_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o
);
  import rau_pkg::*;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } sm_t;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  order;
    logic [1:0]  status;
  } frac_res_t;

  frac_res_t expected_q[$];

  function automatic logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic sm_t to_sm(logic [31:0] w);
    sm_t r;
    r.neg = w[31];
    r.mag = w[31] ? {32'd0, 32'd0 - w} : {32'd0, w};
    return r;
  endfunction

  // sign moves to the numerator, denominator comes back positive
  function automatic void reduce_frac(inout sm_t n, inout sm_t d);
    logic [63:0] g;
    logic        neg;
    g   = gcd_u64(n.mag, d.mag);
    neg = (n.neg != d.neg) && (n.mag != 0);
    if (g == 0) g = 1;
    n.mag = n.mag / g;
    d.mag = d.mag / g;
    n.neg = neg && (n.mag != 0);
    d.neg = 1'b0;
  endfunction

  function automatic sm_t sm_add(sm_t x, sm_t y);
    sm_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic frac_res_t compute_fraction(logic [2:0] act, logic [31:0] anw,
                                                 logic [31:0] adw, logic [31:0] bnw,
                                                 logic [31:0] bdw);
    sm_t         an, ad, bn, bd, rn, rd, t1, t2, l, r;
    logic [63:0] g, lim;
    logic [1:0]  ord, st;
    logic        produce;
    frac_res_t   res;
    an = to_sm(anw); ad = to_sm(adw); bn = to_sm(bnw); bd = to_sm(bdw);
    rn = '{1'b0, 64'd0};
    rd = '{1'b0, 64'd1};
    ord = 2'd0;
    st = ST_OK;
    produce = 1'b0;
    lim = 64'd1 << (WIDTH - 1);
    if (act > ACT_CMP) begin
      // unused action gives the neutral result
    end else if (ad.mag == 0 || (act != ACT_REDUCE && bd.mag == 0)) begin
      st = ST_ZDEN;
    end else begin
      reduce_frac(an, ad);
      if (act != ACT_REDUCE) reduce_frac(bn, bd);
      case (act)
        ACT_REDUCE: begin
          rn = an; rd = ad; produce = 1'b1;
        end
        ACT_ADD, ACT_SUB: begin
          g = gcd_u64(ad.mag, bd.mag);
          t1.neg = an.neg; t1.mag = an.mag * (bd.mag / g);
          t2.neg = bn.neg; t2.mag = bn.mag * (ad.mag / g);
          if (act == ACT_SUB && t2.mag != 0) t2.neg = !t2.neg;
          rn = sm_add(t1, t2);
          rd.neg = 1'b0; rd.mag = (ad.mag / g) * bd.mag;
          produce = 1'b1;
        end
        ACT_MUL: begin
          rn.neg = an.neg != bn.neg; rn.mag = an.mag * bn.mag;
          rd.neg = 1'b0; rd.mag = ad.mag * bd.mag;
          produce = 1'b1;
        end
        ACT_DIV: begin
          if (bn.mag == 0) begin
            st = ST_DIVZ;
          end else begin
            rn.neg = an.neg != bn.neg; rn.mag = an.mag * bd.mag;
            rd.neg = 1'b0; rd.mag = ad.mag * bn.mag;
            produce = 1'b1;
          end
        end
        default: begin
          l.neg = an.neg; l.mag = an.mag * bd.mag;
          r.neg = bn.neg; r.mag = bn.mag * ad.mag;
          if (l.mag == 0) l.neg = 1'b0;
          if (r.mag == 0) r.neg = 1'b0;
          if (l.neg != r.neg) ord = l.neg ? 2'b11 : 2'b01;
          else if (l.mag == r.mag) ord = 2'b00;
          else if (l.neg) ord = (l.mag > r.mag) ? 2'b11 : 2'b01;
          else ord = (l.mag < r.mag) ? 2'b11 : 2'b01;
        end
      endcase
      if (produce) begin
        if (rn.mag == 0) rn.neg = 1'b0;
        reduce_frac(rn, rd);
        if ((rn.neg ? rn.mag > lim : rn.mag > lim - 1) || rd.mag > lim - 1) begin
          st = ST_OVF;
          rn = '{1'b0, 64'd0};
          rd.mag = 64'd1;
        end
      end
    end
    res.num    = rn.neg ? (32'd0 - rn.mag[31:0]) : rn.mag[31:0];
    res.den    = rd.mag[30:0];
    res.order  = ord;
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o  = 0;
    results_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    frac_res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(compute_fraction(action_i, a_num_i, a_den_i, b_num_i, b_den_i));
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", {1'b0, res_den_i}, res_num_i);
        end else begin
          want = expected_q.pop_front();
          if (res_num_i !== want.num) report_mismatch("res_num", res_num_i, want.num);
          if (res_den_i !== want.den) report_mismatch("res_den", res_den_i, want.den);
          if (order_i !== want.order) report_mismatch("order", order_i, want.order);
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- dv/tb_rational_arith_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_arith_unit
// directed corner fractions then random well-formed and noisy operands with
// random stalls on both channels; results checked by rau_checker
// ----------------------------------------------------------------------------
module tb_rational_arith_unit;
  import rau_pkg::*;

  localparam logic [2:0] ACT_UNUSED6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED7 = 3'd7;
  localparam int         N_RANDOM    = 1880;
  localparam logic [31:0] MIN_INT    = 32'h8000_0000;
  localparam logic [31:0] MAX_INT    = 32'h7fff_ffff;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  action_i = '0;
  logic [31:0] a_num_i = '0, a_den_i = 32'd1, b_num_i = '0, b_den_i = 32'd1;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic [1:0]  order_o, status_o;
  int          errors, pending, results, sent;
  logic        hold_quiet = 1'b0;
  logic        long_holdoff = 1'b0;

  rational_arith_unit #(.WIDTH(32)) dut (.*);

  rau_checker #(.WIDTH(32)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .res_num_i(res_num_o), .res_den_i(res_den_o),
    .order_i(order_o), .status_i(status_o),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #80_000_000;
    $display("timeout with %0d transactions outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls, one quiet stretch and one long hold-off
  initial begin
    int cnt;
    forever begin
      @(posedge clk_i);
      if (long_holdoff) begin
        out_ready_i <= 1'b0;
        for (cnt = 0; cnt < 3000; cnt++) @(posedge clk_i);
        long_holdoff = 1'b0;
      end
      out_ready_i <= hold_quiet || ($urandom_range(0, 99) >= 31);
    end
  end

  task automatic send_item(logic [2:0] act, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    in_valid_i <= 1'b1;
    action_i   <= act;
    a_num_i    <= an;
    a_den_i    <= ad;
    b_num_i    <= bn;
    b_den_i    <= bd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    if (!hold_quiet && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_field();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 40) - 20;
      4:          v = $urandom_range(0, 2000) - 1000;
      5:          v = $urandom;
      6:          v = ($urandom_range(0, 1) ? MIN_INT : MAX_INT) + $urandom_range(0, 2);
      7:          v = $urandom_range(0, 131072) - 65536;
      8:          v = ($urandom_range(1, 60) * $urandom_range(1, 60)) *
                      ($urandom_range(0, 1) ? 1 : -1);
      default:    v = ($urandom_range(0, 1) ? 32'd1 << $urandom_range(0, 31) : 32'd0) -
                      $urandom_range(0, 1);
    endcase
    return v;
  endfunction

  initial begin
    int          i;
    logic [2:0]  act;
    sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_item(ACT_REDUCE, 32'd6, 32'd4, 32'd0, 32'd0);
    send_item(ACT_REDUCE, 32'd0, 32'd7, 32'd0, 32'd0);
    send_item(ACT_REDUCE, MIN_INT, 32'hffff_ffff, 32'd0, 32'd0);
    send_item(ACT_REDUCE, MIN_INT, MIN_INT, 32'd5, 32'd0);
    send_item(ACT_REDUCE, MAX_INT, 32'hffff_fffe, 32'd0, 32'd0);
    send_item(ACT_REDUCE, 32'd3, 32'd0, 32'd1, 32'd1);
    send_item(ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_item(ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
    send_item(ACT_ADD, 32'd1, 32'd6, 32'd1, 32'd3);
    send_item(ACT_ADD, MAX_INT, 32'd1, MAX_INT, 32'd1);
    send_item(ACT_ADD, MIN_INT, 32'd1, MIN_INT, 32'd1);
    send_item(ACT_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_item(ACT_SUB, MIN_INT, 32'd1, 32'd1, 32'd1);
    send_item(ACT_SUB, 32'd1, MAX_INT, 32'd1, 32'h7fff_fffe);
    send_item(ACT_MUL, 32'hffff_fffd, 32'd4, 32'd8, 32'hffff_fffa);
    send_item(ACT_MUL, MIN_INT, 32'd1, 32'hffff_ffff, 32'd1);
    send_item(ACT_MUL, MAX_INT, 32'd3, 32'd3, MAX_INT);
    send_item(ACT_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
    send_item(ACT_DIV, 32'd2, 32'd3, 32'hffff_fffc, 32'd9);
    send_item(ACT_DIV, 32'd1, MAX_INT, MAX_INT, 32'd1);
    send_item(ACT_CMP, 32'd1, 32'd3, 32'd2, 32'd6);
    send_item(ACT_CMP, MIN_INT, 32'd1, MAX_INT, 32'd1);
    send_item(ACT_CMP, 32'd0, 32'hffff_ffff, 32'd0, 32'd5);
    send_item(ACT_CMP, 32'd1, 32'd0, 32'd1, 32'd1);
    send_item(ACT_UNUSED6, 32'd5, 32'd0, 32'd1, 32'd0);
    send_item(ACT_UNUSED7, MIN_INT, MAX_INT, MIN_INT, MAX_INT);

    for (i = 0; i < N_RANDOM; i++) begin
      hold_quiet = (i >= 400 && i < 600);
      if (i == 800) begin
        long_holdoff = 1'b1;
      end
      if (i == 1200) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 99) < 5) act = 3'($urandom_range(6, 7));
      else act = 3'($urandom_range(0, 5));
      send_item(act, pick_field(), pick_field(), pick_field(), pick_field());
    end
    in_valid_i <= 1'b0;
    hold_quiet = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);

    $display("%0d operand pairs over all actions sent, %0d results compared", sent, results);
    $display("random stalls on both channels, one long output hold-off, one drain pause");
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
